>>> hw/rtl/load_cell_median_outlier_filter_macros.svh
// Assertion macros for the load cell median outlier filter.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef LOAD_CELL_MEDIAN_OUTLIER_FILTER_MACROS_SVH
`define LOAD_CELL_MEDIAN_OUTLIER_FILTER_MACROS_SVH

// Same-cycle implication.
`define LCMF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LCMF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/lcmf_pkg.sv
// Shared constants, action and register codes, and address helper
// for the load cell median outlier filter. No dependencies.
package lcmf_pkg;

  localparam int HIST_DEPTH = 20;
  localparam int PTR_W      = 5;
  localparam int CNT_W      = 5;
  localparam int RAW_W      = 24;
  localparam int SAMPLE_W   = 25;
  localparam int REQ_W      = 6;
  localparam int TARE_W     = 25;
  localparam int SCALE_W    = 32;
  localparam int DIFF_W     = 26;
  localparam int PROD_W     = 58;
  localparam int ACC_W      = 60;
  localparam int WEIGHT_W   = 57;
  localparam int USED_W     = 5;
  localparam int DIV_W      = ACC_W;
  localparam int DIVS_W     = 5;
  localparam int DIV_CNT_W  = $clog2(DIV_W + 1);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int ACT_W      = 2;
  localparam int RECIP_W    = 32;
  localparam int LIM_PROD_W = SAMPLE_W + RECIP_W;
  localparam int RECIP_SHIFT = 35;

  localparam logic [CNT_W-1:0]      WEIGHT_SAMPLES = CNT_W'(4);
  localparam logic [RECIP_W-1:0]    RECIP_10       = 32'hCCCC_CCCD;
  localparam logic [SCALE_W-1:0]    SCALE_RESET    = 32'h0100_0000;
  localparam logic [PTR_W-1:0]      DEPTH_PTR      = PTR_W'(HIST_DEPTH);
  localparam logic [PTR_W:0]        DEPTH_EXT      = (PTR_W+1)'(HIST_DEPTH);
  localparam logic signed [ACC_W-1:0] W_MAX =
    {{(ACC_W-WEIGHT_W+1){1'b0}}, {(WEIGHT_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] W_MIN = ~W_MAX;

  localparam logic [ACT_W-1:0] ACT_PUSH   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_WEIGHT = 2'd1;
  localparam logic [ACT_W-1:0] ACT_RAW    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_TARE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 2'd1;

  // Entry holding the k-th newest sample.
  function automatic logic [PTR_W-1:0] hist_addr(input logic [PTR_W-1:0] wp,
                                                 input logic [CNT_W-1:0] k);
    logic [PTR_W:0] t;
    t = {1'b0, wp} + DEPTH_EXT - (PTR_W+1)'(1) - {1'b0, k};
    if (t >= DEPTH_EXT) begin
      t = t - DEPTH_EXT;
    end
    return t[PTR_W-1:0];
  endfunction

endpackage

>>> hw/rtl/lcmf_hist_ram.sv
// Sample history memory: one write port, two registered read ports.
// Depends on lcmf_pkg.
module lcmf_hist_ram (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [lcmf_pkg::PTR_W-1:0]    waddr_i,
  input  logic [lcmf_pkg::SAMPLE_W-1:0] wdata_i,
  input  logic [lcmf_pkg::PTR_W-1:0]    raddr_a_i,
  input  logic [lcmf_pkg::PTR_W-1:0]    raddr_b_i,
  output logic [lcmf_pkg::SAMPLE_W-1:0] rdata_a_o,
  output logic [lcmf_pkg::SAMPLE_W-1:0] rdata_b_o
);
  import lcmf_pkg::*;

  logic [SAMPLE_W-1:0] mem [HIST_DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

>>> hw/rtl/lcmf_div.sv
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on lcmf_pkg.
module lcmf_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [lcmf_pkg::DIV_W-1:0]  dividend_i,
  input  logic [lcmf_pkg::DIVS_W-1:0] divisor_i,
  output logic                        done_o,
  output logic [lcmf_pkg::DIV_W-1:0]  quotient_o
);
  import lcmf_pkg::*;

  logic                 busy_q, done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIVS_W-1:0]    den_q, rem_q;
  logic [DIV_W-1:0]     quo_q;
  logic [DIVS_W:0]      trial;
  logic                 ge;

  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      den_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(DIV_W);
        den_q  <= divisor_i;
        rem_q  <= '0;
        quo_q  <= dividend_i;
      end else if (busy_q) begin
        rem_q <= ge ? DIVS_W'(trial - {1'b0, den_q}) : trial[DIVS_W-1:0];
        quo_q <= {quo_q[DIV_W-2:0], ge};
        cnt_q <= cnt_q - DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

>>> hw/rtl/load_cell_median_outlier_filter.sv
// Load cell median outlier filter: top level with control sequencer.
// Depends on lcmf_pkg, lcmf_hist_ram, lcmf_div and the macros header.
//
// Use: a command word is taken when start_i is high and busy_o is low.
// action_i push stores the negated, sign-extended raw_sample_i in the
// 20-entry history and gives no result. A weight query uses
// the newest 4 samples, a raw query the newest request_count_i samples,
// both clamped to the fill level. Queries give one result word, shown for
// one cycle with result_valid_o; the receiver cannot stall and must take it.
// Query steps: rank counting (two history reads per
// cycle), then the median and its median/10 limit (reciprocal
// multiply), then filtering and accumulation, and last the
// mean division. An empty selection answers the cycle after
// accept. A push leaves busy_o low. busy_o is high while a query
// runs and drops as its result word shows.
// Configuration words on cfg_valid_i/cfg_ready_o are always taken.
// Reset clears fill level, write pointer and registers; history contents
// are not cleared and are never read before being written.
`include "load_cell_median_outlier_filter_macros.svh"
module load_cell_median_outlier_filter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [lcmf_pkg::ACT_W-1:0]      action_i,
  input  logic [lcmf_pkg::RAW_W-1:0]      raw_sample_i,
  input  logic [lcmf_pkg::REQ_W-1:0]      request_count_i,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [lcmf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [lcmf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                            result_valid_o,
  output logic                            status_o,
  output logic [lcmf_pkg::USED_W-1:0]     used_samples_o,
  output logic signed [lcmf_pkg::WEIGHT_W-1:0] weight_value_o,
  output logic signed [lcmf_pkg::SAMPLE_W-1:0] raw_average_o
);
  import lcmf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_RANK, S_MED, S_LIM, S_FILT, S_QDIV, S_QWAIT
  } state_e;

  state_e                     state_q;
  logic [CNT_W-1:0]           fill_q, wp_q, n_q, i_q, j_q, ti_q, tj_q, cnt_q;
  logic [TARE_W-1:0]          tare_q;
  logic [SCALE_W-1:0]         scale_q;
  logic                       weight_q, iss_done_q, rv_q, rl_q, v1_q, l1_q, v2_q, l2_q;
  logic [SAMPLE_W-1:0]        lo_q, hi_q, med_q, lim_q, fv_q;
  logic signed [ACC_W-1:0]    term_q, acc_q;
  logic                       res_valid_q, status_q;
  logic [USED_W-1:0]          used_q;
  logic [WEIGHT_W-1:0]        weight_val_q;
  logic [SAMPLE_W-1:0]        raw_avg_q;

  logic                       accept, push_we;
  logic [REQ_W-1:0]           want;
  logic [CNT_W-1:0]           n_sel, cnt_n, m_hi;
  logic [SAMPLE_W-1:0]        push_data, rd_a, rd_b, med_d, med_abs, filt;
  logic [LIM_PROD_W-1:0]      lim_prod;
  logic [PTR_W-1:0]           raddr_a, raddr_b;
  logic                       less;
  logic [SAMPLE_W:0]          pair_sum, pair_adj;
  logic signed [DIFF_W-1:0]   dev, dev_abs, tdiff;
  logic signed [PROD_W-1:0]   prod;
  logic                       div_start, div_done;
  logic [DIV_W-1:0]           div_dividend, div_quot, acc_abs;
  logic [DIVS_W-1:0]          div_divisor;
  logic signed [ACC_W-1:0]    res_s;

  assign accept      = start_i && !busy_o;
  assign busy_o      = state_q != S_IDLE;
  assign cfg_ready_o = 1'b1;
  assign push_we     = accept && action_i == ACT_PUSH;
  assign push_data   = SAMPLE_W'(0) - {raw_sample_i[RAW_W-1], raw_sample_i};

  assign want  = (action_i == ACT_WEIGHT) ? REQ_W'(WEIGHT_SAMPLES) : request_count_i;
  assign n_sel = (want < {1'b0, fill_q}) ? want[CNT_W-1:0] : fill_q;

  assign raddr_a = hist_addr(wp_q, i_q);
  assign raddr_b = hist_addr(wp_q, j_q);

  lcmf_hist_ram u_ram (
    .clk_i     (clk_i),
    .we_i      (push_we),
    .waddr_i   (wp_q),
    .wdata_i   (push_data),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  // Rank with index tie-break gives a strict order.
  assign less  = ($signed(rd_b) < $signed(rd_a)) || (rd_b == rd_a && tj_q < ti_q);
  assign cnt_n = ((tj_q == '0) ? CNT_W'(0) : cnt_q) + CNT_W'(less);
  assign m_hi  = n_q >> 1;

  assign pair_sum = {lo_q[SAMPLE_W-1], lo_q} + {hi_q[SAMPLE_W-1], hi_q};
  assign pair_adj = (pair_sum[SAMPLE_W] && pair_sum[0]) ?
                    pair_sum + (SAMPLE_W+1)'(1) : pair_sum;
  assign med_d    = n_q[0] ? hi_q : pair_adj[SAMPLE_W:1];
  assign med_abs  = med_q[SAMPLE_W-1] ? SAMPLE_W'(0) - med_q : med_q;
  assign lim_prod = LIM_PROD_W'(med_abs) * LIM_PROD_W'(RECIP_10);

  assign dev     = $signed({rd_a[SAMPLE_W-1], rd_a}) - $signed({med_q[SAMPLE_W-1], med_q});
  assign dev_abs = dev[DIFF_W-1] ? -dev : dev;
  assign filt    = ($unsigned(dev_abs) > {1'b0, lim_q}) ? med_q : rd_a;

  assign tdiff = $signed({fv_q[SAMPLE_W-1], fv_q}) - $signed({tare_q[TARE_W-1], tare_q});
  assign prod  = tdiff * $signed(scale_q);

  assign acc_abs      = acc_q[ACC_W-1] ? DIV_W'(-acc_q) : DIV_W'(acc_q);
  assign div_start    = state_q == S_QDIV;
  assign div_dividend = acc_abs;
  assign div_divisor  = n_q;

  lcmf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  assign res_s = acc_q[ACC_W-1] ? -$signed(div_quot) : $signed(div_quot);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      fill_q       <= '0;
      wp_q         <= '0;
      n_q          <= '0;
      i_q          <= '0;
      j_q          <= '0;
      ti_q         <= '0;
      tj_q         <= '0;
      cnt_q        <= '0;
      tare_q       <= '0;
      scale_q      <= SCALE_RESET;
      weight_q     <= 1'b0;
      iss_done_q   <= 1'b0;
      rv_q         <= 1'b0;
      rl_q         <= 1'b0;
      v1_q         <= 1'b0;
      l1_q         <= 1'b0;
      v2_q         <= 1'b0;
      l2_q         <= 1'b0;
      lo_q         <= '0;
      hi_q         <= '0;
      med_q        <= '0;
      lim_q        <= '0;
      fv_q         <= '0;
      term_q       <= '0;
      acc_q        <= '0;
      res_valid_q  <= 1'b0;
      status_q     <= 1'b0;
      used_q       <= '0;
      weight_val_q <= '0;
      raw_avg_q    <= '0;
    end else begin
      res_valid_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_TARE:  tare_q  <= cfg_data_i[TARE_W-1:0];
          CFG_SCALE: scale_q <= cfg_data_i[SCALE_W-1:0];
          default: ;
        endcase
      end
      case (state_q)
        S_IDLE: begin
          if (push_we) begin
            wp_q <= (wp_q == DEPTH_PTR - PTR_W'(1)) ? PTR_W'(0) : wp_q + PTR_W'(1);
            if (fill_q != DEPTH_PTR) begin
              fill_q <= fill_q + CNT_W'(1);
            end
          end else if (accept && (action_i == ACT_WEIGHT || action_i == ACT_RAW)) begin
            weight_q <= action_i == ACT_WEIGHT;
            n_q      <= n_sel;
            if (n_sel == '0) begin
              res_valid_q  <= 1'b1;
              status_q     <= 1'b1;
              used_q       <= '0;
              weight_val_q <= '0;
              raw_avg_q    <= '0;
            end else begin
              i_q        <= '0;
              j_q        <= '0;
              iss_done_q <= 1'b0;
              rv_q       <= 1'b0;
              state_q    <= S_RANK;
            end
          end
        end
        S_RANK: begin
          rv_q <= !iss_done_q;
          ti_q <= i_q;
          tj_q <= j_q;
          if (!iss_done_q) begin
            if (j_q == n_q - CNT_W'(1)) begin
              j_q <= '0;
              if (i_q == n_q - CNT_W'(1)) begin
                iss_done_q <= 1'b1;
              end else begin
                i_q <= i_q + CNT_W'(1);
              end
            end else begin
              j_q <= j_q + CNT_W'(1);
            end
          end
          if (rv_q) begin
            cnt_q <= cnt_n;
            if (tj_q == n_q - CNT_W'(1)) begin
              if (cnt_n == m_hi) begin
                hi_q <= rd_a;
              end
              if (cnt_n == m_hi - CNT_W'(1)) begin
                lo_q <= rd_a;
              end
              if (ti_q == n_q - CNT_W'(1)) begin
                state_q <= S_MED;
              end
            end
          end
        end
        S_MED: begin
          med_q   <= med_d;
          state_q <= S_LIM;
        end
        S_LIM: begin
          lim_q      <= SAMPLE_W'(lim_prod[LIM_PROD_W-1:RECIP_SHIFT]);
          i_q        <= '0;
          iss_done_q <= 1'b0;
          rv_q       <= 1'b0;
          v1_q       <= 1'b0;
          v2_q       <= 1'b0;
          acc_q      <= '0;
          state_q    <= S_FILT;
        end
        S_FILT: begin
          rv_q <= !iss_done_q;
          rl_q <= i_q == n_q - CNT_W'(1);
          if (!iss_done_q) begin
            if (i_q == n_q - CNT_W'(1)) begin
              iss_done_q <= 1'b1;
            end else begin
              i_q <= i_q + CNT_W'(1);
            end
          end
          v1_q <= rv_q;
          l1_q <= rl_q;
          fv_q <= filt;
          v2_q <= v1_q;
          l2_q <= l1_q;
          term_q <= weight_q ? ACC_W'(prod) : ACC_W'($signed(fv_q));
          if (v2_q) begin
            acc_q <= acc_q + term_q;
            if (l2_q) begin
              state_q <= S_QDIV;
            end
          end
        end
        S_QDIV: begin
          state_q <= S_QWAIT;
        end
        S_QWAIT: begin
          if (div_done) begin
            res_valid_q <= 1'b1;
            status_q    <= 1'b0;
            used_q      <= n_q;
            if (weight_q) begin
              raw_avg_q <= '0;
              if (res_s > W_MAX) begin
                weight_val_q <= W_MAX[WEIGHT_W-1:0];
              end else if (res_s < W_MIN) begin
                weight_val_q <= W_MIN[WEIGHT_W-1:0];
              end else begin
                weight_val_q <= res_s[WEIGHT_W-1:0];
              end
            end else begin
              weight_val_q <= '0;
              raw_avg_q    <= res_s[SAMPLE_W-1:0];
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign result_valid_o = res_valid_q;
  assign status_o       = status_q;
  assign used_samples_o = used_q;
  assign weight_value_o = weight_val_q;
  assign raw_average_o  = raw_avg_q;

  `LCMF_ASSERT_IMP(a_fill_range, 1'b1, fill_q <= DEPTH_PTR, "fill level above depth")
  `LCMF_ASSERT_IMP(a_used_nonzero, result_valid_o && !status_o, used_samples_o != '0, "valid result with no samples")
  `LCMF_ASSERT_NXT(a_query_busy, accept && (action_i == ACT_WEIGHT || action_i == ACT_RAW) && n_sel != '0, busy_o, "query did not start")
  `LCMF_ASSERT_IMP(a_div_owner, div_done, state_q == S_QWAIT, "divider done outside a wait")

endmodule

>>> test/load_cell_median_outlier_filter_checker.sv
// Checker for the load cell median outlier filter: watches the command,
// config and result channels, predicts each query result and compares it.
// Depends on lcmf_pkg for widths and action and register codes.
module load_cell_median_outlier_filter_checker
  import lcmf_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic                        busy_o,
  input  logic [ACT_W-1:0]            action_i,
  input  logic [RAW_W-1:0]            raw_sample_i,
  input  logic [REQ_W-1:0]            request_count_i,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                        result_valid_o,
  input  logic                        status_o,
  input  logic [USED_W-1:0]           used_samples_o,
  input  logic signed [WEIGHT_W-1:0]  weight_value_o,
  input  logic signed [SAMPLE_W-1:0]  raw_average_o,
  output int                          fail_count,
  output int                          pending_count,
  output int                          result_count
);

  typedef struct packed {
    logic                       status;
    logic [USED_W-1:0]          used;
    logic signed [WEIGHT_W-1:0] weight;
    logic signed [SAMPLE_W-1:0] rawavg;
  } filter_result_t;

  filter_result_t expected_results[$];
  longint history[HIST_DEPTH];
  int     fill;
  int     wpos;
  longint tare;
  longint scale;

  task automatic report(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
    fail_count++;
  endtask

  function automatic filter_result_t predict_query(input logic [ACT_W-1:0] act,
                                                   input int want_cnt);
    filter_result_t r;
    longint buf_v[HIST_DEPTH];
    longint v, med, lim, sum, mean;
    int n, j;
    r = '0;
    n = (want_cnt < fill) ? want_cnt : fill;
    if (n == 0) begin
      r.status = 1'b1;
      return r;
    end
    for (int k = 0; k < n; k++) buf_v[k] = history[(wpos + HIST_DEPTH - 1 - k) % HIST_DEPTH];
    for (int k = 1; k < n; k++) begin
      v = buf_v[k];
      j = k;
      while (j > 0 && buf_v[j-1] > v) begin
        buf_v[j] = buf_v[j-1];
        j--;
      end
      buf_v[j] = v;
    end
    med = (n % 2 == 0) ? (buf_v[n/2] + buf_v[n/2-1]) / 2 : buf_v[n/2];
    lim = med / 10;
    if (lim < 0) lim = -lim;
    sum = 0;
    for (int k = 0; k < n; k++) begin
      v = buf_v[k] - med;
      if (v < 0) v = -v;
      if (v > lim) buf_v[k] = med;
      sum += (act == ACT_WEIGHT) ? (buf_v[k] - tare) * scale : buf_v[k];
    end
    mean = sum / n;
    r.used = USED_W'(n);
    if (act == ACT_WEIGHT) begin
      if (mean > W_MAX) mean = W_MAX;
      if (mean < W_MIN) mean = W_MIN;
      r.weight = WEIGHT_W'(mean);
    end else begin
      r.rawavg = SAMPLE_W'(mean);
    end
    return r;
  endfunction

  assign pending_count = expected_results.size();

  always @(posedge clk_i or negedge rst_ni) begin
    filter_result_t got, want;
    if (!rst_ni) begin
      fill = 0;
      wpos = 0;
      tare = 0;
      scale = longint'(signed'(SCALE_RESET));
      fail_count = 0;
      result_count = 0;
      expected_results.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_TARE) tare = longint'(signed'(cfg_data_i[TARE_W-1:0]));
        else if (cfg_index_i == CFG_SCALE) scale = longint'(signed'(cfg_data_i));
      end
      if (result_valid_o) begin
        got = '{status_o, used_samples_o, weight_value_o, raw_average_o};
        result_count++;
        if (expected_results.size() == 0) begin
          report("unexpected result word", 0, 0);
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status) report("status", got.status, want.status);
          if (got.used !== want.used) report("used_samples", got.used, want.used);
          if (got.weight !== want.weight) report("weight_value", got.weight, want.weight);
          if (got.rawavg !== want.rawavg) report("raw_average", got.rawavg, want.rawavg);
        end
      end
      if (start_i && !busy_o) begin
        if (action_i == ACT_PUSH) begin
          history[wpos] = -longint'(signed'(raw_sample_i));
          wpos = (wpos + 1) % HIST_DEPTH;
          if (fill < HIST_DEPTH) fill++;
        end else if (action_i == ACT_WEIGHT) begin
          expected_results.push_back(predict_query(action_i, int'(WEIGHT_SAMPLES)));
        end else if (action_i == ACT_RAW) begin
          expected_results.push_back(predict_query(action_i, int'(request_count_i)));
        end
      end
    end
  end

endmodule

>>> test/load_cell_median_outlier_filter_tb.sv
// Testbench top for the load cell median outlier filter: drives pushes,
// queries and config words, and gives the verdict from the checker's count.
// Depends on lcmf_pkg, the block and load_cell_median_outlier_filter_checker.
module load_cell_median_outlier_filter_tb;
  import lcmf_pkg::*;

  localparam logic [ACT_W-1:0]     ACT_NONE  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd2;
  localparam int                   RUN_LIMIT = 3000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic [ACT_W-1:0] action_i = ACT_PUSH;
  logic [RAW_W-1:0] raw_sample_i = '0;
  logic [REQ_W-1:0] request_count_i = '0;
  logic cfg_valid_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = CFG_TARE;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic busy_o, cfg_ready_o, result_valid_o, status_o;
  logic [USED_W-1:0] used_samples_o;
  logic signed [WEIGHT_W-1:0] weight_value_o;
  logic signed [SAMPLE_W-1:0] raw_average_o;
  int fail_count, pending_count, result_count;
  int cycles = 0;
  int items = 0;
  bit no_gaps = 1'b0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  load_cell_median_outlier_filter dut (.*);
  load_cell_median_outlier_filter_checker chk (.*);

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("load_cell_median_outlier_filter test failed");
      $finish;
    end
  end

  task automatic send(input logic [ACT_W-1:0] act, input logic [RAW_W-1:0] raw,
                      input logic [REQ_W-1:0] cnt);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    action_i <= act;
    raw_sample_i <= raw;
    request_count_i <= cnt;
    start_i <= 1'b1;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    @(negedge clk_i);
    items++;
  endtask

  task automatic drain;
    start_i <= 1'b0;
    @(negedge clk_i);
    while (pending_count != 0 || busy_o) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_index_i <= idx;
    cfg_data_i <= data;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic random_phase(input int count);
    logic [RAW_W-1:0] base, raw;
    int spread, pick;
    base = RAW_W'($urandom());
    spread = $urandom_range(0, 3000);
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        if ($urandom_range(0, 11) == 0) raw = RAW_W'($urandom());
        else raw = base + RAW_W'($urandom_range(0, 2 * spread)) - RAW_W'(spread);
        send(ACT_PUSH, raw, REQ_W'($urandom()));
      end else if (pick < 58) begin
        send(ACT_PUSH, RAW_W'($urandom()), REQ_W'($urandom()));
      end else if (pick < 78) begin
        send(ACT_RAW, RAW_W'($urandom()),
             ($urandom_range(0, 7) == 0) ? REQ_W'($urandom_range(21, 63))
                                         : REQ_W'($urandom_range(0, 20)));
      end else if (pick < 97) begin
        send(ACT_WEIGHT, RAW_W'($urandom()), REQ_W'($urandom()));
      end else begin
        send(ACT_NONE, RAW_W'($urandom()), REQ_W'($urandom()));
      end
    end
    drain();
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // empty history and unused action code
    send(ACT_WEIGHT, '0, '0);
    send(ACT_RAW, '0, 6'd5);
    send(ACT_NONE, 24'hFFFFFF, 6'd63);
    send(ACT_PUSH, 24'h800000, '0);
    send(ACT_RAW, '0, 6'd0);
    send(ACT_RAW, '0, 6'd1);
    send(ACT_PUSH, 24'h7FFFFF, '0);
    send(ACT_PUSH, 24'hFFFFFF, '0);
    send(ACT_PUSH, 24'h000000, '0);
    send(ACT_WEIGHT, '0, '0);
    send(ACT_RAW, '0, 6'd2);
    send(ACT_RAW, '0, 6'd3);
    for (int i = 0; i < 18; i++) send(ACT_PUSH, 24'h001000 + RAW_W'(i * 7), '0);
    send(ACT_RAW, '0, 6'd63);
    send(ACT_RAW, '0, 6'd20);
    send(ACT_WEIGHT, '0, '0);
    drain();
    write_reg(CFG_TARE, 32'h0080_0000);
    write_reg(CFG_SCALE, 32'h7FFF_FFFF);
    write_reg(CFG_SPARE, 32'hFFFF_FFFF);
    send(ACT_PUSH, 24'h800000, '0);
    send(ACT_WEIGHT, '0, '0);
    drain();
    write_reg(CFG_TARE, 32'h1FF8_0001);
    write_reg(CFG_SCALE, 32'h8000_0000);
    send(ACT_PUSH, 24'h7FFFFF, '0);
    send(ACT_WEIGHT, '0, '0);
    drain();
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin write_reg(CFG_TARE, '0); write_reg(CFG_SCALE, 32'h0100_0000); end
        1: begin write_reg(CFG_TARE, 32'h1FF8_0001); write_reg(CFG_SCALE, 32'h7FFF_FFFF); end
        2: begin write_reg(CFG_TARE, 32'h0080_0000); write_reg(CFG_SCALE, 32'h8000_0000); end
        default: begin
          write_reg(CFG_TARE, $urandom());
          write_reg(CFG_SCALE, $urandom());
        end
      endcase
      random_phase(225);
    end
    repeat (20) @(negedge clk_i);
    $display("Covered %0d command words and %0d result words over 5 config settings.",
             items, result_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("load_cell_median_outlier_filter test passed");
    end else begin
      $display("load_cell_median_outlier_filter test failed");
    end
    $finish;
  end

endmodule
